FILE: hdl/salru_pkg.sv
// Shared types, constants and helpers for the set-associative LRU lookup unit.
// Used by salru_ctrl, salru_dp and set_assoc_cache_lru_lookup_unit.
package salru_pkg;

  localparam int MAX_SETS_DEF  = 64;
  localparam int MAX_WAYS_DEF  = 8;
  localparam int ADDR_BITS_DEF = 32;

  localparam int ADDR_W      = 32;
  localparam int TAG_W       = 32;
  localparam int RANK_W      = 4;
  localparam int CNT_W       = 32;
  localparam int WAY_OUT_W   = 3;
  localparam int IB_W        = 4;
  localparam int WC_W        = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_WAY_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } salru_state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic lookup;
  } salru_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } salru_sts_t;

  function automatic int floor_log2(input int n);
    int b;
    b = 0;
    while ((2 << b) <= n) b++;
    return b;
  endfunction

endpackage

FILE: hdl/salru_ctrl.sv
// Controller state machine: clearing pass, idle, lookup/write-back.
// Depends on salru_pkg; drives commands into salru_dp.
module salru_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  salru_pkg::salru_sts_t sts,
  output salru_pkg::salru_cmd_t cmd
);
  import salru_pkg::*;

  salru_state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (sts.out_free) begin
          cmd.lookup = 1'b1;
          in_tready  = 1'b1;
          if (in_tvalid) cmd.accept = 1'b1;
          else state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

endmodule

FILE: hdl/salru_dp.sv
// Datapath: config registers, set memories, tag compare, victim pick, recency
// update, hit/miss counters and output register. Depends on salru_pkg.
module salru_dp #(
  parameter int MAX_SETS  = salru_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS  = salru_pkg::MAX_WAYS_DEF,
  parameter int ADDR_BITS = salru_pkg::ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [salru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [salru_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [salru_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  salru_pkg::salru_cmd_t              cmd,
  output salru_pkg::salru_sts_t              sts
);
  import salru_pkg::*;

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int MIB   = floor_log2(MAX_SETS);
  localparam logic [ADDR_W-1:0] AMASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                        ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  logic [CFG_DATA_W-1:0] way_count_r;
  logic [2:0]            index_bits_r;
  logic [3:0]            offset_bits_r;

  logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_mem  [MAX_SETS];
  logic [MAX_WAYS-1:0]             val_mem  [MAX_SETS];
  logic [MAX_WAYS-1:0][RANK_W-1:0] rank_mem [MAX_SETS];

  logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tag_r;
  logic [MAX_WAYS-1:0]             rd_val_r;
  logic [MAX_WAYS-1:0][RANK_W-1:0] rd_rank_r;
  logic [SET_W-1:0]                set_r;
  logic [TAG_W-1:0]                req_tag_r;
  logic [SET_W-1:0]                clr_cnt_r;

  logic [CNT_W-1:0] hits_r, hits_nxt, misses_r, misses_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r;
  logic [WAY_OUT_W-1:0] out_way_r;

  // request decode
  logic [ADDR_W-1:0] addr, blk;
  logic [IB_W-1:0]   ib_eff;
  logic [SET_W-1:0]  set_mask, set_idx;
  logic [TAG_W-1:0]  tag_in;

  always_comb begin
    addr     = in_tdata[ADDR_W-1:0] & AMASK;
    blk      = addr >> offset_bits_r;
    ib_eff   = ({1'b0, index_bits_r} > IB_W'(MIB)) ? IB_W'(MIB) : {1'b0, index_bits_r};
    set_mask = ~({SET_W{1'b1}} << ib_eff);
    set_idx  = SET_W'(blk) & set_mask;
    tag_in   = TAG_W'(blk >> ib_eff);
  end

  // lookup
  logic [WC_W-1:0]     wc;
  logic [MAX_WAYS-1:0] active, hitv, freev, lruv, others;
  logic                found, have_free;
  logic [WAY_W-1:0]    hit_way, free_way, lru_way, pick;
  logic [RANK_W-1:0]   pick_rank;
  logic [MAX_WAYS-1:0][RANK_W-1:0] new_rank;
  logic [WAY_W:0]      used;

  logic                            wr_en;
  logic [SET_W-1:0]                wr_addr;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  wr_tag;
  logic [MAX_WAYS-1:0]             wr_val;
  logic [MAX_WAYS-1:0][RANK_W-1:0] wr_rank;

  always_comb begin
    if (way_count_r == '0) wc = WC_W'(1);
    else if ({1'b0, way_count_r} > WC_W'(MAX_WAYS)) wc = WC_W'(MAX_WAYS);
    else wc = {1'b0, way_count_r};

    for (int w = 0; w < MAX_WAYS; w++) begin
      active[w] = WC_W'(w) < wc;
      hitv[w]   = active[w] && rd_val_r[w] && (rd_tag_r[w] == req_tag_r);
      freev[w]  = active[w] && (rd_rank_r[w] == '0);
      lruv[w]   = active[w];
      for (int v = 0; v < MAX_WAYS; v++) begin
        if (v != w && active[v]) begin
          if (v < w) lruv[w] = lruv[w] && (rd_rank_r[w] < rd_rank_r[v]);
          else lruv[w] = lruv[w] && (rd_rank_r[w] <= rd_rank_r[v]);
        end
      end
    end
    found     = |hitv;
    have_free = |freev;

    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hitv[w])  hit_way  = WAY_W'(w);
      if (freev[w]) free_way = WAY_W'(w);
      if (lruv[w])  lru_way  = WAY_W'(w);
    end
    pick      = found ? hit_way : (have_free ? free_way : lru_way);
    pick_rank = rd_rank_r[pick];

    new_rank = rd_rank_r;
    others   = '0;
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (active[v] && WAY_W'(v) != pick) begin
        if (pick_rank != '0 && rd_rank_r[v] > pick_rank)
          new_rank[v] = rd_rank_r[v] - RANK_W'(1);
        others[v] = new_rank[v] != '0;
      end
    end
    used           = (WAY_W + 1)'($countones(others));
    new_rank[pick] = RANK_W'(used) + RANK_W'(1);

    wr_en   = cmd.clear || cmd.lookup;
    wr_addr = cmd.clear ? clr_cnt_r : set_r;
    wr_tag  = rd_tag_r;
    wr_val  = '0;
    wr_rank = '0;
    if (!cmd.clear) begin
      wr_val  = rd_val_r;
      wr_rank = new_rank;
      if (!found) begin
        wr_tag[pick] = req_tag_r;
        wr_val[pick] = 1'b1;
      end
    end

    hits_nxt      = hits_r + CNT_W'(found);
    misses_nxt    = misses_r + CNT_W'(!found);
    out_valid_nxt = cmd.lookup || (out_valid_r && !out_tready);

    sts.out_free   = !out_valid_r || out_tready;
    sts.clear_last = clr_cnt_r == SET_W'(MAX_SETS - 1);
  end

  // set memories, read registered, write-back forwarded to a same-set read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr]  <= wr_tag;
      val_mem[wr_addr]  <= wr_val;
      rank_mem[wr_addr] <= wr_rank;
    end
    if (cmd.accept) begin
      set_r     <= set_idx;
      req_tag_r <= tag_in;
      if (wr_en && wr_addr == set_idx) begin
        rd_tag_r  <= wr_tag;
        rd_val_r  <= wr_val;
        rd_rank_r <= wr_rank;
      end else begin
        rd_tag_r  <= tag_mem[set_idx];
        rd_val_r  <= val_mem[set_idx];
        rd_rank_r <= rank_mem[set_idx];
      end
    end
    if (cmd.lookup) begin
      out_hit_r <= found;
      out_way_r <= WAY_OUT_W'(pick);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      way_count_r   <= CFG_DATA_W'(1);
      index_bits_r  <= '0;
      offset_bits_r <= '0;
      clr_cnt_r     <= '0;
      hits_r        <= '0;
      misses_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WAY_COUNT:   way_count_r   <= cfg_data;
          CFG_INDEX_BITS:  index_bits_r  <= cfg_data[2:0];
          CFG_OFFSET_BITS: offset_bits_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + SET_W'(1);
      if (cmd.lookup) begin
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, misses_r, hits_r, out_way_r, out_hit_r};

  a_lookup_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |=> out_valid_r)
    else $error("lookup did not load output register");

  a_lookup_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |-> (!out_valid_r || out_tready))
    else $error("lookup overwrote a pending result");

  a_one_count_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |=> (hits_r + misses_r) == ($past(hits_r) + $past(misses_r) + 32'd1))
    else $error("hit/miss counters out of step");

  a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !cmd.accept && !cmd.lookup)
    else $error("item activity during clearing pass");

endmodule

FILE: hdl/set_assoc_cache_lru_lookup_unit.sv
// Top level of the set-associative cache lookup unit with LRU replacement.
// Depends on salru_pkg, salru_ctrl and salru_dp.
//
// Usage:
//   in_*  : one item per byte address (in_tdata[31:0]).
//   out_* : one item per address: hit, way used, running hit and miss counts.
//   cfg_* : register writes (0 way count, 1 index bits, 2 offset bits), always
//           ready; write them only while no item is in flight.
// Path: the set row is read on accept; the result loads once the output is free.
// Throughput: one item per cycle while the output drains. Each item is a
//   read-modify-write of its set row: the row is read on the accept edge and
//   written back on the lookup edge; a following item to the same set sees the
//   written row through a bypass on the set memory read port.
// Reset: valid and recency of every set are cleared by a pass over all sets,
//   one set per cycle; in_tready stays low until it ends. Counters, config
//   registers and out_tvalid return to their reset values.
// Stall: with a result waiting and out_tready low, one more item is taken and
//   read, then in_tready drops until the result is taken.
module set_assoc_cache_lru_lookup_unit #(
  parameter int MAX_SETS  = salru_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS  = salru_pkg::MAX_WAYS_DEF,
  parameter int ADDR_BITS = salru_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [salru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [salru_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] address
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [salru_pkg::OUT_TDATA_W-1:0] out_tdata   // [0] hit, [3:1] way_used,
                                                        // [35:4] hit_count,
                                                        // [67:36] miss_count
);
  import salru_pkg::*;

  salru_cmd_t cmd;
  salru_sts_t sts;

  assign cfg_ready = 1'b1;

  salru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  salru_dp #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
